/* design/hpc_pkg.sv */
// shared constants, types and hash arithmetic for the hashed path cache
package hpc_pkg;

	// table geometry (depth must be a power of two)
	localparam int TABLE_DEPTH = 1024;
	localparam int INDEX_W = $clog2(TABLE_DEPTH);

	// field widths
	localparam int CHAR_W = 8;
	localparam int HANDLE_W = 32;
	localparam int TAG_W = 32;
	localparam int IN_DATA_W = ((CHAR_W + 2 * HANDLE_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + 2 * HANDLE_W + INDEX_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;

	// polynomial hash arithmetic
	localparam longint POLY_MOD = 64'd1000000009;
	localparam int POLY_BASE = 31;
	localparam int POWER_W = 30;            // base power < POLY_MOD < 2**30
	localparam int MAG_W = 8;               // |weight| <= 224
	localparam int MAG_MAX = 224;
	localparam int PROD_W = POWER_W + MAG_W;
	localparam int COARSE_SHIFT = 30;
	localparam int RED_W = 31;              // coarse residue < 2**30 + POLY_MOD
	localparam int SUM_W = 31;              // |running sum| < POLY_MOD
	localparam logic [RED_W-1:0] MOD_R = RED_W'(POLY_MOD);
	localparam logic [RED_W-1:0] MOD2_R = RED_W'(2 * POLY_MOD);
	localparam logic signed [SUM_W:0] MOD_S = (SUM_W + 1)'(POLY_MOD);
	localparam logic signed [CHAR_W:0] WEIGHT_OFFSET = 9'sd96;  // 'a' - 1
	localparam logic [POWER_W-1:0] POWER_SEED = POWER_W'(1);

	// djb2 tag
	localparam logic [TAG_W-1:0] TAG_SEED = 32'd5381;
	localparam logic [TAG_W-1:0] TAG_MULT = 32'd33;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_PUT    = 1'b1
	} op_t;

	// one stored row
	typedef struct packed {
		logic [TAG_W-1:0]    tag;
		logic [HANDLE_W-1:0] entry;
		logic [HANDLE_W-1:0] link;
	} row_t;

	// finished key handed from the hash pipeline to the table
	typedef struct packed {
		op_t                 op;
		logic [TAG_W-1:0]    tag;
		logic [HANDLE_W-1:0] entry;
		logic [HANDLE_W-1:0] link;
		logic [INDEX_W-1:0]  slot;
	} key_t;

	// subtract the largest k*POLY_MOD judged from the top bits; result < 2**30 + POLY_MOD
	function automatic logic [RED_W-1:0] coarse_mod(input logic [PROD_W-1:0] x);
		logic [PROD_W-COARSE_SHIFT-1:0] hi;
		logic [PROD_W-1:0] qm;
		longint thr;
		hi = x[PROD_W-1:COARSE_SHIFT];
		qm = '0;
		for (int k = 1; k <= MAG_MAX; k++) begin
			thr = (longint'(k) * POLY_MOD + (longint'(1) <<< COARSE_SHIFT) - 1) >>> COARSE_SHIFT;
			if (64'(hi) >= 64'(thr))
				qm = PROD_W'(longint'(k) * POLY_MOD);
		end
		return RED_W'(x - qm);
	endfunction

	// final correction to [0, POLY_MOD)
	function automatic logic [POWER_W-1:0] fine_mod(input logic [RED_W-1:0] y);
		logic [POWER_W-1:0] r;
		if (y >= MOD2_R)
			r = POWER_W'(y - MOD2_R);
		else if (y >= MOD_R)
			r = POWER_W'(y - MOD_R);
		else
			r = POWER_W'(y);
		return r;
	endfunction

	// base power times 31, reduced
	function automatic logic [POWER_W-1:0] next_power(input logic [POWER_W-1:0] p);
		logic [PROD_W-1:0] x;
		x = PROD_W'(p) * PROD_W'(POLY_BASE);
		return fine_mod(coarse_mod(x));
	endfunction

	// truncating remainder of acc + t, given |t| mod M, sign of t and whether |t| >= M
	function automatic logic signed [SUM_W-1:0] poly_step(
		input logic signed [SUM_W-1:0] acc,
		input logic [POWER_W-1:0]      r,
		input logic                    neg,
		input logic                    big
	);
		logic signed [SUM_W:0] u;
		logic signed [SUM_W:0] rs;
		rs = $signed((SUM_W + 1)'(r));
		u = neg ? ((SUM_W + 1)'(acc) - rs) : ((SUM_W + 1)'(acc) + rs);
		if (!big) begin
			if (u >= MOD_S)
				u = u - MOD_S;
			else if (u <= -MOD_S)
				u = u + MOD_S;
		end else if (!neg) begin
			// true sum is positive: fold into [0, M)
			if (u < 0)
				u = u + MOD_S;
			else if (u >= MOD_S)
				u = u - MOD_S;
		end else begin
			// true sum is negative: fold into (-M, 0]
			if (u > 0)
				u = u - MOD_S;
			else if (u <= -MOD_S)
				u = u + MOD_S;
		end
		return SUM_W'(u);
	endfunction

	// |acc % TABLE_DEPTH| for a power-of-two depth
	function automatic logic [INDEX_W-1:0] slot_of(input logic signed [SUM_W-1:0] acc);
		logic [INDEX_W-1:0] lo;
		lo = acc[INDEX_W-1:0];
		return acc[SUM_W-1] ? ((~lo) + INDEX_W'(1)) : lo;
	endfunction

endpackage

/* design/hpc_hash.sv */
// hash pipeline: per-character djb2 tag and polynomial sum, emits one key per last character
module hpc_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_accept,
	input  logic                          adv,
	input  logic [hpc_pkg::CHAR_W-1:0]    char_code,
	input  logic                          last_char,
	input  hpc_pkg::op_t                  opcode,
	input  logic [hpc_pkg::HANDLE_W-1:0]  entry_in,
	input  logic [hpc_pkg::HANDLE_W-1:0]  link_in,
	output logic                          key_valid,
	output hpc_pkg::key_t                 key
);

	typedef struct packed {
		logic                          last;
		hpc_pkg::op_t                  op;
		logic [hpc_pkg::TAG_W-1:0]     tag;
		logic [hpc_pkg::HANDLE_W-1:0]  entry;
		logic [hpc_pkg::HANDLE_W-1:0]  link;
	} carry_t;

	logic [hpc_pkg::POWER_W-1:0]       power_q;
	logic [hpc_pkg::TAG_W-1:0]         tag_q;
	logic signed [hpc_pkg::SUM_W-1:0]  sum_q;

	logic signed [hpc_pkg::CHAR_W:0]   weight;
	logic [hpc_pkg::TAG_W-1:0]         tag_next;
	logic signed [hpc_pkg::SUM_W-1:0]  sum_next;

	logic                              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	carry_t                            carry_s1, carry_s2, carry_s3, carry_s4, carry_s5;
	logic                              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [hpc_pkg::MAG_W-1:0]         mag_s1;
	logic [hpc_pkg::POWER_W-1:0]       power_s1;
	logic [hpc_pkg::PROD_W-1:0]        prod_s2;
	logic [hpc_pkg::RED_W-1:0]         red_s3;
	logic                              big_s3, big_s4;
	logic [hpc_pkg::POWER_W-1:0]       rem_s4;
	logic signed [hpc_pkg::SUM_W-1:0]  sum_s5;

	// character weight and next tag
	always_comb begin
		weight = $signed({char_code[hpc_pkg::CHAR_W-1], char_code}) - hpc_pkg::WEIGHT_OFFSET;
		tag_next = tag_q * hpc_pkg::TAG_MULT
			+ {{(hpc_pkg::TAG_W - hpc_pkg::CHAR_W){char_code[hpc_pkg::CHAR_W-1]}}, char_code};
	end

	// accumulate the reduced term into the running sum
	assign sum_next = hpc_pkg::poly_step(sum_q, rem_s4, neg_s4, big_s4);

	// running state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q  <= hpc_pkg::POWER_SEED;
			tag_q    <= hpc_pkg::TAG_SEED;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_accept) begin
				power_q <= last_char ? hpc_pkg::POWER_SEED : hpc_pkg::next_power(power_q);
				tag_q   <= last_char ? hpc_pkg::TAG_SEED : tag_next;
			end
			if (adv) begin
				valid_s1 <= in_accept;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
				valid_s5 <= valid_s4 && carry_s4.last;
				if (valid_s4)
					sum_q <= carry_s4.last ? '0 : sum_next;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s1 <= '{last: last_char, op: opcode, tag: tag_next,
				entry: entry_in, link: link_in};
			neg_s1   <= weight[hpc_pkg::CHAR_W];
			mag_s1   <= weight[hpc_pkg::CHAR_W] ? hpc_pkg::MAG_W'(-weight)
				: hpc_pkg::MAG_W'(weight);
			power_s1 <= power_q;

			// term magnitude
			carry_s2 <= carry_s1;
			neg_s2   <= neg_s1;
			prod_s2  <= hpc_pkg::PROD_W'(mag_s1) * hpc_pkg::PROD_W'(power_s1);

			// coarse reduction
			carry_s3 <= carry_s2;
			neg_s3   <= neg_s2;
			red_s3   <= hpc_pkg::coarse_mod(prod_s2);
			big_s3   <= prod_s2 >= hpc_pkg::PROD_W'(hpc_pkg::POLY_MOD);

			// final reduction
			carry_s4 <= carry_s3;
			neg_s4   <= neg_s3;
			big_s4   <= big_s3;
			rem_s4   <= hpc_pkg::fine_mod(red_s3);

			// finished key
			carry_s5 <= carry_s4;
			sum_s5   <= sum_next;
		end
	end

	// key toward the table
	always_comb begin
		key_valid = valid_s5;
		key.op    = carry_s5.op;
		key.tag   = carry_s5.tag;
		key.entry = carry_s5.entry;
		key.link  = carry_s5.link;
		key.slot  = hpc_pkg::slot_of(sum_s5);
	end

endmodule

/* design/hpc_table.sv */
// direct-mapped table: clearing pass, put writes, lookup read, compare and result register
module hpc_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          key_valid,
	input  hpc_pkg::key_t                 key,
	input  logic                          adv,
	input  logic                          out_ready,
	output logic                          busy,
	output logic                          s6_open,
	output logic                          out_valid,
	output logic                          hit,
	output logic [hpc_pkg::HANDLE_W-1:0]  entry_out,
	output logic [hpc_pkg::HANDLE_W-1:0]  link_out,
	output logic [hpc_pkg::INDEX_W-1:0]   slot_index
);

	hpc_pkg::row_t                  mem [hpc_pkg::TABLE_DEPTH];

	logic                           busy_q;
	logic [hpc_pkg::INDEX_W-1:0]    clr_addr_q;
	logic                           valid_s6;
	hpc_pkg::row_t                  row_s6;
	logic [hpc_pkg::TAG_W-1:0]      tag_s6;
	logic [hpc_pkg::INDEX_W-1:0]    slot_s6;
	logic                           out_valid_q;
	logic                           hit_q;
	logic [hpc_pkg::HANDLE_W-1:0]   entry_q;
	logic [hpc_pkg::HANDLE_W-1:0]   link_q;
	logic [hpc_pkg::INDEX_W-1:0]    slot_q;

	logic                           out_free;
	logic                           s6_move;
	logic                           wr_en;
	logic                           rd_en;
	logic [hpc_pkg::INDEX_W-1:0]    wr_addr;
	hpc_pkg::row_t                  wr_row;

	// port control
	always_comb begin
		out_free = !out_valid_q || out_ready;
		s6_move  = valid_s6 && out_free;
		s6_open  = !valid_s6 || out_free;
		rd_en    = adv && key_valid && (key.op == hpc_pkg::OP_LOOKUP);
		wr_en    = busy_q || (adv && key_valid && (key.op == hpc_pkg::OP_PUT));
		wr_addr  = busy_q ? clr_addr_q : key.slot;
		wr_row   = busy_q ? hpc_pkg::row_t'('0)
			: hpc_pkg::row_t'{tag: key.tag, entry: key.entry, link: key.link};
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (rd_en) begin
			row_s6  <= mem[key.slot];
			tag_s6  <= key.tag;
			slot_s6 <= key.slot;
		end
	end

	// clearing pass and valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			clr_addr_q  <= '0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_addr_q <= clr_addr_q + hpc_pkg::INDEX_W'(1);
				if (clr_addr_q == hpc_pkg::INDEX_W'(hpc_pkg::TABLE_DEPTH - 1))
					busy_q <= 1'b0;
			end
			if (rd_en)
				valid_s6 <= 1'b1;
			else if (s6_move)
				valid_s6 <= 1'b0;
			if (s6_move)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// tag compare into the result register
	always_ff @(posedge clk) begin
		if (s6_move) begin
			hit_q   <= row_s6.tag == tag_s6;
			entry_q <= (row_s6.tag == tag_s6) ? row_s6.entry : '0;
			link_q  <= row_s6.link;
			slot_q  <= slot_s6;
		end
	end

	assign busy       = busy_q;
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign entry_out  = entry_q;
	assign link_out   = link_q;
	assign slot_index = slot_q;

endmodule

/* design/hashed_path_cache_unit.sv */
// top level of the hashed path cache: stream ports, stall control and checks
//
// A key streams in on the s_axis channel, one character per request, the final
// character marked by tlast; tuser carries the operation (0 lookup, 1 put) and
// is looked at on the final character only. A put stores the key's djb2 tag and
// the two handles in the slot picked by the polynomial hash and returns nothing.
// A lookup returns one result on m_axis: hit, the entry handle (zero on a miss),
// the stored link handle and the slot index.
// Throughput is one character per cycle while s_axis_tready is high. After its
// last character is taken, a lookup passes five hash stages (weight, multiply,
// two reduction steps, accumulate), the table read, then the compare register.
// The recurrence that sets the pace is the accumulate of the reduced term into
// the registered running sum.
// After reset all 1024 slots are swept to zero, one slot a cycle;
// s_axis_tready stays low until the sweep is done.
// When the receiver stalls, the result waits in its output register and one
// more lookup waits behind it; characters keep flowing until a third lookup
// reaches the table stage, then s_axis_tready drops.
module hashed_path_cache_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [hpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // char_code, entry_in, link_in
	input  logic                             s_axis_tlast,   // last_char
	input  logic                             s_axis_tuser,   // opcode
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [hpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // hit, entry_out, link_out,
	                                                         // slot_index, zero pad
);

	logic                           in_accept;
	logic                           adv;
	logic                           busy;
	logic                           s6_open;
	logic                           key_valid;
	hpc_pkg::key_t                  key;
	logic [hpc_pkg::CHAR_W-1:0]     char_code;
	logic [hpc_pkg::HANDLE_W-1:0]   entry_in;
	logic [hpc_pkg::HANDLE_W-1:0]   link_in;
	logic                           hit;
	logic [hpc_pkg::HANDLE_W-1:0]   entry_out;
	logic [hpc_pkg::HANDLE_W-1:0]   link_out;
	logic [hpc_pkg::INDEX_W-1:0]    slot_index;

	// request unpacking
	assign char_code = s_axis_tdata[hpc_pkg::CHAR_W-1:0];
	assign entry_in  = s_axis_tdata[hpc_pkg::CHAR_W +: hpc_pkg::HANDLE_W];
	assign link_in   = s_axis_tdata[hpc_pkg::CHAR_W + hpc_pkg::HANDLE_W +: hpc_pkg::HANDLE_W];

	// hold the hash pipeline only when a lookup cannot enter the table stage
	assign adv = !(key_valid && (key.op == hpc_pkg::OP_LOOKUP)) || s6_open;
	assign s_axis_tready = !busy && adv;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	hpc_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.adv       (adv),
		.char_code (char_code),
		.last_char (s_axis_tlast),
		.opcode    (hpc_pkg::op_t'(s_axis_tuser)),
		.entry_in  (entry_in),
		.link_in   (link_in),
		.key_valid (key_valid),
		.key       (key)
	);

	hpc_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key        (key),
		.adv        (adv),
		.out_ready  (m_axis_tready),
		.busy       (busy),
		.s6_open    (s6_open),
		.out_valid  (m_axis_tvalid),
		.hit        (hit),
		.entry_out  (entry_out),
		.link_out   (link_out),
		.slot_index (slot_index)
	);

	// result packing
	assign m_axis_tdata = {hpc_pkg::OUT_PAD_W'(0), slot_index, link_out, entry_out, hit};

	// no request taken during the clearing sweep
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("request accepted during table clearing");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tready && !busy) |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked result");

	// a held lookup key stays put until the table stage opens
	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && (key.op == hpc_pkg::OP_LOOKUP) && !adv) |=> (key_valid && $stable(key)))
		else $error("stalled lookup key changed");

	// a miss never returns an entry handle
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !hit) |-> (entry_out == '0))
		else $error("entry handle returned on a miss");

endmodule

/* dv/hashed_path_cache_unit_tb.sv */
// testbench for the hashed path cache: random keys, in-order prediction, field checks
`timescale 1ns / 1ps

module hashed_path_cache_unit_tb;

	localparam longint HASH_MOD = 64'd1000000009;
	localparam longint HASH_BASE = 31;
	localparam longint CHAR_BIAS = 96;          // 'a' - 1
	localparam longint SLOT_COUNT = hpc_pkg::TABLE_DEPTH;
	localparam logic [31:0] DJB_SEED = 32'd5381;
	localparam int POOL_KEYS = 48;
	localparam int MAX_KEY_LEN = 24;
	localparam int RANDOM_CHARS = 1000;
	localparam int DRAIN_AT_KEY = 150;
	localparam int LONG_STALL_AT = 40;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	// one key character as offered on the input stream
	typedef struct {
		logic [7:0]     code;
		logic           last;
		hpc_pkg::op_t   op;
		logic [31:0]    entry;
		logic [31:0]    link;
		bit             drain;      // hold this one back until all lookups are back
	} key_char_t;

	// what a lookup should return
	typedef struct {
		logic        hit;
		logic [31:0] entry;
		logic [31:0] link;
		logic [9:0]  slot;
	} lookup_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [hpc_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;    // char_code, entry_in, link_in
	logic s_axis_tlast = 1'b0;                            // last_char
	logic s_axis_tuser = 1'b0;                            // opcode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [hpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // hit, entry_out, link_out,
	                                                      // slot_index, zero pad

	key_char_t char_q[$];
	lookup_result_t lookup_q[$];
	logic [7:0] key_buf[$];
	key_char_t cur_char;
	int chars_queued = 0;
	int chars_done = 0;
	int gap_left = 0;
	bit send_burst = 1'b0;
	int stall_left = 0;
	bit recv_burst = 1'b0;
	int results_seen = 0;
	int fail_count = 0;

	// running hashes and table contents
	longint poly_acc = 0;
	longint power_acc = 1;
	logic [31:0] djb_acc = DJB_SEED;
	logic [31:0] tag_tbl[hpc_pkg::TABLE_DEPTH] = '{default: '0};
	logic [31:0] entry_tbl[hpc_pkg::TABLE_DEPTH] = '{default: '0};
	logic [31:0] link_tbl[hpc_pkg::TABLE_DEPTH] = '{default: '0};

	hashed_path_cache_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// advance both hashes by one character; on the last one touch the table
	function automatic void hash_key_char(input key_char_t c);
		longint ch;
		longint rem;
		int slot;
		logic [31:0] tag;
		lookup_result_t res;
		ch = longint'($signed(c.code));
		poly_acc = (poly_acc + (ch - CHAR_BIAS) * power_acc) % HASH_MOD;
		power_acc = (power_acc * HASH_BASE) % HASH_MOD;
		djb_acc = djb_acc * 32'd33 + 32'(ch);
		if (c.last) begin
			rem = poly_acc % SLOT_COUNT;
			if (rem < 0)
				rem = -rem;
			slot = int'(rem);
			tag = djb_acc;
			poly_acc = 0;
			power_acc = 1;
			djb_acc = DJB_SEED;
			if (c.op == hpc_pkg::OP_PUT) begin
				tag_tbl[slot] = tag;
				entry_tbl[slot] = c.entry;
				link_tbl[slot] = c.link;
			end else begin
				res.hit = (tag_tbl[slot] == tag);
				res.entry = res.hit ? entry_tbl[slot] : 32'd0;
				res.link = link_tbl[slot];
				res.slot = 10'(slot);
				lookup_q.push_back(res);
			end
		end
	endfunction

	// compare one returned lookup against the oldest prediction
	function automatic void check_lookup(input logic [hpc_pkg::OUT_DATA_W-1:0] d);
		lookup_result_t exp_res;
		if (lookup_q.size() == 0) begin
			$error("lookup result with nothing expected: %h", d);
			fail_count++;
		end else begin
			exp_res = lookup_q.pop_front();
			if (d[0] !== exp_res.hit) begin
				$error("hit mismatch: expected %0d, got %0d", exp_res.hit, d[0]);
				fail_count++;
			end
			if (d[32:1] !== exp_res.entry) begin
				$error("entry_out mismatch: expected %h, got %h", exp_res.entry, d[32:1]);
				fail_count++;
			end
			if (d[64:33] !== exp_res.link) begin
				$error("link_out mismatch: expected %h, got %h", exp_res.link, d[64:33]);
				fail_count++;
			end
			if (d[74:65] !== exp_res.slot) begin
				$error("slot_index mismatch: expected %0d, got %0d", exp_res.slot, d[74:65]);
				fail_count++;
			end
		end
	endfunction

	// turn the key in key_buf into requests; only the last char carries the real op
	task automatic queue_key(input hpc_pkg::op_t op, input logic [31:0] ent,
			input logic [31:0] lnk, input bit drain);
		key_char_t c;
		foreach (key_buf[i]) begin
			c.code = key_buf[i];
			c.last = (i == key_buf.size() - 1);
			c.op = c.last ? op : hpc_pkg::op_t'($urandom_range(0, 1));
			c.entry = c.last ? ent : $urandom;
			c.link = c.last ? lnk : $urandom;
			c.drain = drain && (i == 0);
			char_q.push_back(c);
		end
		chars_queued += key_buf.size();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// input side: one request per item, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			s_axis_tuser <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_key_char(cur_char);
				chars_done++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (char_q.size() != 0 &&
						!(char_q[0].drain && lookup_q.size() != 0)) begin
					cur_char = char_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cur_char.link, cur_char.entry, cur_char.code};
					s_axis_tlast <= cur_char.last;
					s_axis_tuser <= cur_char.op;
					if ($urandom_range(0, 15) == 0)
						send_burst <= !send_burst;
					gap_left <= send_burst ? 0 : $urandom_range(0, 7);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: check each result, then stall for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_lookup(m_axis_tdata);
				results_seen++;
				if (results_seen == LONG_STALL_AT) begin
					stall_left = LONG_STALL_CYCLES;
				end else begin
					if ($urandom_range(0, 15) == 0)
						recv_burst = !recv_burst;
					stall_left = recv_burst ? 0 : $urandom_range(0, 7);
				end
			end else if (stall_left != 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	// stimulus and end of run
	initial begin
		longint pw;
		longint s;
		longint d;
		int pool_len[POOL_KEYS];
		logic [7:0] pool_chars[POOL_KEYS][MAX_KEY_LEN];
		int len;
		int pick;
		int keys_sent;
		hpc_pkg::op_t op;
		logic [31:0] ent;
		logic [31:0] lnk;

		// key whose djb2 tag wraps to zero: hits an unwritten slot with zero handles
		pw = 1;
		repeat (7) pw = pw * 33;
		s = (-(longint'(DJB_SEED) * pw)) & 64'hFFFF_FFFF;
		if (s >= (longint'(1) << 31))
			s = s - (longint'(1) << 32);
		key_buf.delete();
		repeat (7) begin
			d = s % 33;
			if (d > 16)
				d = d - 33;
			else if (d < -16)
				d = d + 33;
			key_buf.push_front(8'(d));
			s = (s - d) / 33;
		end
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);

		// miss on an empty slot, then put and hit with all-ones entry
		key_buf = '{8'h61};
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);
		queue_key(hpc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);

		// character code zero, stored with no entry handle
		key_buf = '{8'h00};
		queue_key(hpc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);

		// negative characters drive the running sum below zero
		key_buf = '{8'h80, 8'hFF};
		queue_key(hpc_pkg::OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);
		key_buf = '{8'h7F, 8'h01, 8'h80};
		queue_key(hpc_pkg::OP_LOOKUP, 32'd0, 32'd0, 1'b0);

		// pool of reusable keys so puts and lookups meet
		for (int k = 0; k < POOL_KEYS; k++) begin
			pool_len[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, MAX_KEY_LEN)
				: $urandom_range(1, 6);
			for (int j = 0; j < MAX_KEY_LEN; j++)
				pool_chars[k][j] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(97, 122))
					: 8'($urandom_range(0, 255));
		end

		// random keys: mostly from the pool, some fresh
		keys_sent = 0;
		while (chars_queued < RANDOM_CHARS) begin
			key_buf.delete();
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 8);
				repeat (len) key_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				pick = $urandom_range(0, POOL_KEYS - 1);
				for (int j = 0; j < pool_len[pick]; j++)
					key_buf.push_back(pool_chars[pick][j]);
			end
			op = ($urandom_range(0, 2) == 0) ? hpc_pkg::OP_PUT : hpc_pkg::OP_LOOKUP;
			ent = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
			lnk = $urandom;
			queue_key(op, ent, lnk, keys_sent == DRAIN_AT_KEY);
			keys_sent++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every request to be taken and every lookup to come back
		while (chars_done != chars_queued)
			@(posedge clk);
		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard limit on run length
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
